/* design/letp_pkg.sv */
// ----------------------------------------------------------------------------
// Looping envelope table player package
// Shared command codes, register indexes and controller/datapath interface.
// ----------------------------------------------------------------------------
package letp_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned LOAD_ADDR_W = 10;
  localparam int unsigned LOOP_W     = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_START       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_END         = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_START_VALID = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_END_VALID   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENV_LENGTH       = 3'd4;

  localparam logic [LEN_W-1:0] ENV_LENGTH_RESET = 11'd1024;

  typedef enum logic [1:0] {
    RA_PTR  = 2'd0,
    RA_LEND = 2'd1,
    RA_POS  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    wr_en;
    logic    note_on;
    rd_sel_e rd_sel;
    logic    cur_load;
    logic    pos_load;
    logic    srch_step;
    logic    take_pos;
    logic    play;
    logic    emit_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic end_flag;
    logic loop_end_valid;
    logic hit;
  } ctrl_stat_t;

endpackage

/* design/letp_ctrl.sv */
// ----------------------------------------------------------------------------
// Looping envelope table player controller
// Sequences table loads, sample playback and the backward release search.
// ----------------------------------------------------------------------------
module letp_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic [letp_pkg::CMD_W-1:0]     cmd_i,
  input  letp_pkg::ctrl_stat_t           stat_i,
  output letp_pkg::ctrl_cmd_t            cmd_o,
  output logic                           busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PLAY,
    S_SRCH_CUR,
    S_SRCH
  } state_e;

  state_e state_q, state_d;
  logic   rel_q, rel_d;

  always_comb begin
    state_d = state_q;
    rel_d   = rel_q;
    cmd_o   = '0;
    cmd_o.rd_sel = letp_pkg::RA_PTR;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i == letp_pkg::CMD_LOAD) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.note_on = (cmd_i == letp_pkg::CMD_NOTE_ON);
            rel_d         = (cmd_i == letp_pkg::CMD_RELEASE);
            state_d       = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat_i.end_flag) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end else if (rel_q && stat_i.loop_end_valid) begin
          state_d = S_SRCH_CUR;
        end else begin
          state_d = S_PLAY;
        end
      end
      S_PLAY: begin
        cmd_o.play = 1'b1;
        state_d    = S_IDLE;
      end
      S_SRCH_CUR: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.pos_load = 1'b1;
        cmd_o.rd_sel   = letp_pkg::RA_LEND;
        state_d        = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        cmd_o.rd_sel    = letp_pkg::RA_POS;
        if (stat_i.hit) begin
          cmd_o.take_pos = 1'b1;
          state_d        = S_PLAY;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rel_q   <= rel_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* design/letp_datapath.sv */
// ----------------------------------------------------------------------------
// Looping envelope table player datapath
// Envelope table memory, play pointer, loop and end state, search and outputs.
// ----------------------------------------------------------------------------
module letp_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned AMP_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  letp_pkg::ctrl_cmd_t                  cmd_i,
  output letp_pkg::ctrl_stat_t                 stat_o,
  input  logic [letp_pkg::LOAD_ADDR_W-1:0]     load_addr_i,
  input  logic [AMP_BITS-1:0]                  load_value_i,
  input  logic                                 cfg_we_i,
  input  logic [letp_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [letp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                 strobe_o,
  output logic [AMP_BITS-1:0]                  sample_o,
  output logic                                 ended_o
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned PW0 = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW  = (PW0 > letp_pkg::LEN_W) ? PW0 : letp_pkg::LEN_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);

  logic [AMP_BITS-1:0] mem [TABLE_DEPTH];

  logic [letp_pkg::LOOP_W-1:0] loop_start_q, loop_end_q;
  logic                        loop_start_valid_q, loop_end_valid_q;
  logic [letp_pkg::LEN_W-1:0]  env_length_q;

  logic [PW-1:0]       ptr_q, pos_q;
  logic                loop_active_q, end_q;
  logic [AMP_BITS-1:0] cur_q, rd_word_q;
  logic                rd_oor_q;
  logic                strobe_q, ended_q;
  logic [AMP_BITS-1:0] sample_q;

  logic [PW-1:0]       load_addr_ext, len_ext, eff_len, rd_addr, pos_next, ptr_inc, ptr_adv;
  logic [AMP_BITS-1:0] rd_data;
  logic                hit, end_d;

  assign load_addr_ext = PW'(load_addr_i);
  assign len_ext       = PW'(env_length_q);
  assign eff_len       = ((len_ext == '0) || (len_ext > DEPTH_P)) ? DEPTH_P : len_ext;
  assign rd_data       = rd_oor_q ? '0 : rd_word_q;
  assign hit           = (rd_data == cur_q) || (pos_q == '0);
  assign pos_next      = hit ? pos_q : (pos_q - PW'(1));

  always_comb begin
    case (cmd_i.rd_sel)
      letp_pkg::RA_PTR:  rd_addr = ptr_q;
      letp_pkg::RA_LEND: rd_addr = PW'(loop_end_q);
      letp_pkg::RA_POS:  rd_addr = pos_next;
      default:           rd_addr = ptr_q;
    endcase
  end

  assign ptr_inc = ptr_q + PW'(1);
  assign ptr_adv = (loop_active_q && (ptr_inc == PW'(loop_end_q))) ? PW'(loop_start_q) : ptr_inc;
  assign end_d   = (ptr_adv >= eff_len);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (load_addr_ext < DEPTH_P)) begin
      mem[load_addr_ext[AW-1:0]] <= load_value_i;
    end
    rd_word_q <= mem[rd_addr[AW-1:0]];
    rd_oor_q  <= (rd_addr >= DEPTH_P);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_start_q       <= '0;
      loop_end_q         <= '0;
      loop_start_valid_q <= 1'b0;
      loop_end_valid_q   <= 1'b0;
      env_length_q       <= letp_pkg::ENV_LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        letp_pkg::CFG_LOOP_START:       loop_start_q       <= cfg_wdata_i[letp_pkg::LOOP_W-1:0];
        letp_pkg::CFG_LOOP_END:         loop_end_q         <= cfg_wdata_i[letp_pkg::LOOP_W-1:0];
        letp_pkg::CFG_LOOP_START_VALID: loop_start_valid_q <= cfg_wdata_i[0];
        letp_pkg::CFG_LOOP_END_VALID:   loop_end_valid_q   <= cfg_wdata_i[0];
        letp_pkg::CFG_ENV_LENGTH:       env_length_q       <= cfg_wdata_i[letp_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      loop_active_q <= 1'b0;
      end_q         <= 1'b1;
      strobe_q      <= 1'b0;
      ended_q       <= 1'b0;
    end else begin
      strobe_q <= cmd_i.play || cmd_i.emit_end;
      if (cmd_i.note_on) begin
        ptr_q         <= '0;
        loop_active_q <= loop_start_valid_q && loop_end_valid_q;
        end_q         <= 1'b0;
      end else if (cmd_i.take_pos) begin
        ptr_q         <= pos_q;
        loop_active_q <= 1'b0;
      end else if (cmd_i.play) begin
        ptr_q <= ptr_adv;
        end_q <= end_d;
      end
      if (cmd_i.play) begin
        ended_q <= end_d;
      end else if (cmd_i.emit_end) begin
        ended_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_q <= rd_data;
    end
    if (cmd_i.pos_load) begin
      pos_q <= PW'(loop_end_q);
    end else if (cmd_i.srch_step) begin
      pos_q <= pos_next;
    end
    if (cmd_i.play) begin
      sample_q <= rd_data;
    end else if (cmd_i.emit_end) begin
      sample_q <= '0;
    end
  end

  assign stat_o.end_flag       = end_q;
  assign stat_o.loop_end_valid = loop_end_valid_q;
  assign stat_o.hit            = hit;

  assign strobe_o = strobe_q;
  assign sample_o = sample_q;
  assign ended_o  = ended_q;

  // A word is only issued by a playback step or by the silent path.
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(cmd_i.play || cmd_i.emit_end))
    else $error("result word without a playback step");

  a_emit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.play && cmd_i.emit_end))
    else $error("playback and silent word in the same cycle");

  a_silent_when_ended: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_end |-> end_q)
    else $error("silent word while the envelope is running");

  a_ended_tracks_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.play |=> (ended_q == end_q))
    else $error("ended output differs from the end flag");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_end |=> (sample_q == '0) && ended_q)
    else $error("silent word is not zero");

endmodule

/* design/looping_envelope_table_player.sv */
// ----------------------------------------------------------------------------
// Looping envelope table player
// Plays a stored envelope table with a sustain loop and a release search.
// ----------------------------------------------------------------------------
// Channel   Ports                                     Handshake
// input     cmd_i, load_addr_i, load_value_i          start and not busy
// result    sample_o, ended_o                         strobe_o, one cycle
// config    cfg_addr_i, cfg_wdata_i                   cfg_we_i
//
// A load gives no word; busy stays low. A sample, note-on or plain release
// passes S_CHECK and S_PLAY; its word is registered from S_PLAY. Any word on
// an ended envelope is issued from S_CHECK. A release with a valid loop end
// first runs the backward search from loop_end down to the match (or entry 0)
// in S_SRCH_CUR and S_SRCH, one table read per cycle on the single read port.
// Reset clears pointer, loop state, loop registers; sets length 1024, end flag.
// The receiver cannot stall; each word is valid for the single strobe cycle.
// ----------------------------------------------------------------------------
module looping_envelope_table_player #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned AMP_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [letp_pkg::CMD_W-1:0]           cmd_i,
  input  logic [letp_pkg::LOAD_ADDR_W-1:0]     load_addr_i,
  input  logic [AMP_BITS-1:0]                  load_value_i,
  input  logic                                 cfg_we_i,
  input  logic [letp_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [letp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                 strobe_o,
  output logic [AMP_BITS-1:0]                  sample_o,
  output logic                                 ended_o
);

  letp_pkg::ctrl_cmd_t  ctrl_cmd;
  letp_pkg::ctrl_stat_t ctrl_stat;

  letp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (ctrl_stat),
    .cmd_o  (ctrl_cmd),
    .busy   (busy)
  );

  letp_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AMP_BITS    (AMP_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .stat_o       (ctrl_stat),
    .load_addr_i  (load_addr_i),
    .load_value_i (load_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .strobe_o     (strobe_o),
    .sample_o     (sample_o),
    .ended_o      (ended_o)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Looping envelope table player testbench
// Drives a short table of directed commands, then random command words under
// several loop and length settings. Every result word is checked against a plan
// row's word or an in-bench model of table, play pointer, loop and ended state.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = 1024;
  localparam int PHASES = 7;
  localparam int PHASE_WORDS = 64;
  localparam int RAND_WORDS = PHASES * PHASE_WORDS;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PLAN_LEN = 32;
  localparam int CA_W = letp_pkg::CFG_ADDR_W;
  localparam int CD_W = letp_pkg::CFG_DATA_W;
  localparam logic [CA_W-1:0] REG_SPARE = 3'd5;

  localparam letp_pkg::cmd_e OP_SMP = letp_pkg::CMD_SAMPLE;
  localparam letp_pkg::cmd_e OP_ON  = letp_pkg::CMD_NOTE_ON;
  localparam letp_pkg::cmd_e OP_REL = letp_pkg::CMD_RELEASE;
  localparam letp_pkg::cmd_e OP_LD  = letp_pkg::CMD_LOAD;

  localparam logic [CA_W-1:0] RG_LS  = letp_pkg::CFG_LOOP_START;
  localparam logic [CA_W-1:0] RG_LE  = letp_pkg::CFG_LOOP_END;
  localparam logic [CA_W-1:0] RG_LSV = letp_pkg::CFG_LOOP_START_VALID;
  localparam logic [CA_W-1:0] RG_LEV = letp_pkg::CFG_LOOP_END_VALID;
  localparam logic [CA_W-1:0] RG_LEN = letp_pkg::CFG_ENV_LENGTH;

  typedef struct packed {
    logic [15:0] amp;
    logic        ended;
  } env_word_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CA_W-1:0]       reg_idx;
    letp_pkg::cmd_e        op;
    logic [9:0]            addr;
    logic [15:0]           data;
    logic                  typed;
    logic [15:0]           want_amp;
    logic                  want_end;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [letp_pkg::CMD_W-1:0]    cmd_i;
  logic [9:0]                    load_addr_i;
  logic [15:0]                   load_value_i;
  logic                          cfg_we_i;
  logic [CA_W-1:0]               cfg_addr_i;
  logic [CD_W-1:0]               cfg_wdata_i;
  logic                          strobe_o;
  logic [15:0]                   sample_o;
  logic                          ended_o;

  bit [15:0]   env_tbl [DEPTH];
  bit          env_written [DEPTH];
  int unsigned play_ptr;
  bit          loop_on;
  bit          ended_flag;
  logic [9:0]  cfg_ls;
  logic [9:0]  cfg_le;
  bit          cfg_lsv;
  bit          cfg_lev;
  logic [10:0] cfg_len;

  env_word_t pending_env_q [$];
  env_word_t head_word;
  int        mismatches;
  int        words_checked;
  int        words_sent;
  int        loads_sent;
  int        releases_sent;
  int        settings_used;
  int        idle_pct;
  int        cycles;

  plan_row_t plan [0:PLAN_LEN-1] = '{
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{1'b0, RG_LS, OP_REL, 10'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{1'b0, RG_LS, OP_LD, 10'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_LD, 10'd1, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_LD, 10'd2, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_LD, 10'd3, 16'h1234, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_LD, 10'd4, 16'h00FF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_LD, 10'd1023, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LEN, OP_SMP, 10'd0, 16'd3, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_ON, 10'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{1'b0, RG_LS, OP_REL, 10'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{1'b1, RG_LS, OP_SMP, 10'd0, 16'h0401, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LE, OP_SMP, 10'd0, 16'd3, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LSV, OP_SMP, 10'd0, 16'd1, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LEV, OP_SMP, 10'd0, 16'd1, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LEN, OP_SMP, 10'd0, 16'd0, 1'b0, 16'h0000, 1'b0},
    '{1'b1, REG_SPARE, OP_SMP, 10'd0, 16'h07FF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_ON, 10'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_REL, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_REL, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LS, OP_SMP, 10'd0, 16'd5, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LE, OP_SMP, 10'd0, 16'd2, 1'b0, 16'h0000, 1'b0},
    '{1'b1, RG_LEN, OP_SMP, 10'd0, 16'd3, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_ON, 10'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, RG_LS, OP_SMP, 10'd0, 16'h0000, 1'b1, 16'h0000, 1'b1}
  };

  looping_envelope_table_player #(
    .TABLE_DEPTH(DEPTH),
    .AMP_BITS   (16)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .load_addr_i (load_addr_i),
    .load_value_i(load_value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .strobe_o    (strobe_o),
    .sample_o    (sample_o),
    .ended_o     (ended_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] amp_at(input int unsigned idx);
    if (idx >= DEPTH) return 16'h0000;
    return env_tbl[idx];
  endfunction

  // Advances the envelope state by one command word and forms its result.
  function automatic void step_envelope(input letp_pkg::cmd_e op, input logic [9:0] addr,
                                        input logic [15:0] data, output bit has,
                                        output env_word_t w);
    logic [15:0] cur;
    int unsigned pos;
    int unsigned lim;
    has = 1'b0;
    w = '0;
    if (op == OP_LD) begin
      env_tbl[addr] = data;
      env_written[addr] = 1'b1;
      return;
    end
    has = 1'b1;
    if (op == OP_ON) begin
      play_ptr = 0;
      loop_on = cfg_lsv && cfg_lev;
      ended_flag = 1'b0;
    end
    if (ended_flag) begin
      w.ended = 1'b1;
      return;
    end
    if (op == OP_REL && cfg_lev) begin
      cur = amp_at(play_ptr);
      pos = cfg_le;
      while (pos > 0 && amp_at(pos) != cur) pos--;
      play_ptr = pos;
      loop_on = 1'b0;
    end
    w.amp = amp_at(play_ptr);
    play_ptr++;
    if (loop_on && play_ptr == cfg_le) play_ptr = cfg_ls;
    lim = (cfg_len == 0 || cfg_len > DEPTH) ? DEPTH : cfg_len;
    if (play_ptr >= lim) ended_flag = 1'b1;
    w.ended = ended_flag;
  endfunction

  // Returns the first table entry that the command would read before it was
  // ever loaded, or -1. For a release search, want is the amplitude sought.
  function automatic int missing_entry(input letp_pkg::cmd_e op, output logic [15:0] want);
    int unsigned p;
    int unsigned pos;
    bit fin;
    logic [15:0] cur;
    want = 16'h0000;
    if (op == OP_LD) return -1;
    p = play_ptr;
    fin = ended_flag;
    if (op == OP_ON) begin
      p = 0;
      fin = 1'b0;
    end
    if (fin || p >= DEPTH) return -1;
    if (!env_written[p]) return p;
    if (op == OP_REL && cfg_lev) begin
      cur = env_tbl[p];
      want = cur;
      pos = cfg_le;
      while (env_written[pos] && pos > 0 && env_tbl[pos] != cur) pos--;
      if (!env_written[pos]) return pos;
    end
    return -1;
  endfunction

  function automatic logic [15:0] pick_amp();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3, 4: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input letp_pkg::cmd_e op, input logic [9:0] addr,
                           input logic [15:0] data, input bit typed,
                           input env_word_t want);
    env_word_t got;
    bit has;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= op;
    load_addr_i <= addr;
    load_value_i <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    step_envelope(op, addr, data, has, got);
    if (has) pending_env_q.push_back(typed ? want : got);
    words_sent++;
    if (op == OP_LD) loads_sent++;
    if (op == OP_REL) releases_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_env_q.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CA_W-1:0] idx,
                           input logic [CD_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RG_LS:   cfg_ls = data[9:0];
      RG_LE:   cfg_le = data[9:0];
      RG_LSV:  cfg_lsv = data[0];
      RG_LEV:  cfg_lev = data[0];
      RG_LEN:  cfg_len = data[10:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [10:0] ls, input logic [10:0] le,
                               input bit lsv, input bit lev, input logic [10:0] len);
    settle();
    write_reg(RG_LS, ls);
    write_reg(RG_LE, le);
    write_reg(RG_LSV, {10'd0, lsv});
    write_reg(RG_LEV, {10'd0, lev});
    write_reg(RG_LEN, len);
    write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 11'($urandom_range(0, 2047)));
    settings_used++;
  endtask

  // Words that would read an unloaded entry are preceded by the loads they
  // need; half of those loads carry the amplitude a release search looks for.
  task automatic random_word();
    letp_pkg::cmd_e op;
    logic [9:0] addr;
    logic [15:0] data;
    logic [15:0] want;
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 25) op = OP_LD;
    else if (r < 35) op = OP_ON;
    else if (r < 50) op = OP_REL;
    else op = OP_SMP;
    addr = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, DEPTH - 1))
                                        : 10'($urandom_range(0, 63));
    data = pick_amp();
    gap = missing_entry(op, want);
    while (gap >= 0) begin
      send_word(OP_LD, gap[9:0], $urandom_range(0, 1) ? want : pick_amp(),
                1'b0, '0);
      gap = missing_entry(op, want);
    end
    send_word(op, addr, data, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o === 1'b1) begin
      if (pending_env_q.size() == 0) begin
        mismatches++;
        $display("%0t: word with none expected, sample %h ended %b",
                 $time, sample_o, ended_o);
      end else begin
        head_word = pending_env_q.pop_front();
        words_checked++;
        if (sample_o !== head_word.amp) begin
          mismatches++;
          $display("%0t: sample expected %h, actual %h", $time, head_word.amp, sample_o);
        end
        if (ended_o !== head_word.ended) begin
          mismatches++;
          $display("%0t: ended expected %b, actual %b", $time, head_word.ended, ended_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = OP_SMP;
    load_addr_i = '0;
    load_value_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    play_ptr = 0;
    loop_on = 1'b0;
    ended_flag = 1'b1;
    cfg_ls = '0;
    cfg_le = '0;
    cfg_lsv = 1'b0;
    cfg_lev = 1'b0;
    cfg_len = letp_pkg::ENV_LENGTH_RESET;
    mismatches = 0;
    words_checked = 0;
    words_sent = 0;
    loads_sent = 0;
    releases_sent = 0;
    settings_used = 1;
    cycles = 0;
    idle_pct = 16;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].data[CD_W-1:0]);
      end else begin
        send_word(plan[i].op, plan[i].addr, plan[i].data, plan[i].typed,
                  '{plan[i].want_amp, plan[i].want_end});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_setting(11'd2, 11'd9, 1'b1, 1'b1, 11'd16);
        1: apply_setting(11'd0, 11'd0, 1'b1, 1'b1, 11'd1);
        2: apply_setting(11'h7FF, 11'd1023, 1'b1, 1'b1, 11'd1024);
        3: apply_setting(11'd5, 11'd30, 1'b0, 1'b1, 11'd2047);
        4: apply_setting(11'd12, 11'd4, 1'b1, 1'b0, 11'd40);
        5: apply_setting(11'd20, 11'd10, 1'b1, 1'b1, 11'd18);
        default: begin
          apply_setting(11'($urandom_range(0, 63)), 11'($urandom_range(0, 63)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? 11'd0
                                                     : 11'($urandom_range(1, 80)));
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph * PHASE_WORDS + n < RAND_WORDS / 3) idle_pct = 16;
        else if (ph * PHASE_WORDS + n < 2 * RAND_WORDS / 3) idle_pct = 81;
        else idle_pct = 0;
        random_word();
      end
    end

    start <= 1'b0;
    while (pending_env_q.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d command words (%0d loads, %0d releases) over %0d register settings.",
             words_sent, loads_sent, releases_sent, settings_used);
    $display("Checked %0d result words, %0d still outstanding.",
             words_checked, pending_env_q.size());
    if (mismatches == 0 && pending_env_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/letp_pkg.sv
design/letp_ctrl.sv
design/letp_datapath.sv
design/looping_envelope_table_player.sv
tb/sv/tb_top.sv
